### sv/lcd4_pkg.sv
package lcd4_pkg;

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] column;
		logic [2:0] row;
		logic [7:0] char_code;
	} req_t;

	typedef struct packed {
		logic        reg_select;
		logic [3:0]  nibble;
		logic [15:0] wait_before_us;
		logic [12:0] wait_after_us;
		logic        last_of_run;
	} res_t;

	// one classified command between front and back
	typedef struct packed {
		logic       is_init;
		logic       rs;
		logic [7:0] data;
		logic       long_settle;
	} cmd_t;

	localparam logic [2:0] REQ_INIT   = 3'd0;
	localparam logic [2:0] REQ_CLEAR  = 3'd1;
	localparam logic [2:0] REQ_HOME   = 3'd2;
	localparam logic [2:0] REQ_CURSOR = 3'd3;
	localparam logic [2:0] REQ_CHAR   = 3'd4;

	localparam logic [7:0] CMD_CLEAR   = 8'h01;
	localparam logic [7:0] CMD_SET_DDR = 8'h80;

	localparam logic [7:0] ROW_OFFSET [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

	localparam int          QUEUE_DEPTH  = 2;
	localparam logic [3:0]  INIT_LAST    = 4'd13;

	localparam logic [15:0] POWER_UP_US  = 16'd50000;
	localparam logic [12:0] SETTLE_US    = 13'd50;
	localparam logic [12:0] BYTE_US      = 13'd90;
	localparam logic [12:0] LONG_BYTE_US = 13'd2090;
	localparam logic [12:0] WAKE1_US     = 13'd5050;
	localparam logic [12:0] WAKE2_US     = 13'd2050;

	function automatic res_t mk_res(logic rs, logic [3:0] nib, logic [15:0] pre_us,
			logic [12:0] after, logic last);
		res_t r;
		r.reg_select     = rs;
		r.nibble         = nib;
		r.wait_before_us = pre_us;
		r.wait_after_us  = after;
		r.last_of_run    = last;
		return r;
	endfunction

	// wake nibbles, the 4-bit mode nibble, then 0x28 0x08 0x01 0x06 0x0C high nibble first
	function automatic res_t init_strobe(logic [3:0] step);
		res_t r;
		unique case (step)
			4'd0:    r = mk_res(1'b0, 4'h3, POWER_UP_US, WAKE1_US, 1'b0);
			4'd1:    r = mk_res(1'b0, 4'h3, 16'd0, WAKE2_US, 1'b0);
			4'd2:    r = mk_res(1'b0, 4'h3, 16'd0, SETTLE_US, 1'b0);
			4'd3:    r = mk_res(1'b0, 4'h2, 16'd0, SETTLE_US, 1'b0);
			4'd4:    r = mk_res(1'b0, 4'h2, 16'd0, SETTLE_US, 1'b0);
			4'd5:    r = mk_res(1'b0, 4'h8, 16'd0, BYTE_US, 1'b0);
			4'd6:    r = mk_res(1'b0, 4'h0, 16'd0, SETTLE_US, 1'b0);
			4'd7:    r = mk_res(1'b0, 4'h8, 16'd0, BYTE_US, 1'b0);
			4'd8:    r = mk_res(1'b0, 4'h0, 16'd0, SETTLE_US, 1'b0);
			4'd9:    r = mk_res(1'b0, 4'h1, 16'd0, BYTE_US, 1'b0);
			4'd10:   r = mk_res(1'b0, 4'h0, 16'd0, SETTLE_US, 1'b0);
			4'd11:   r = mk_res(1'b0, 4'h6, 16'd0, LONG_BYTE_US, 1'b0);
			4'd12:   r = mk_res(1'b0, 4'h0, 16'd0, SETTLE_US, 1'b0);
			4'd13:   r = mk_res(1'b0, 4'hC, 16'd0, BYTE_US, 1'b1);
			default: r = mk_res(1'b0, 4'h0, 16'd0, SETTLE_US, 1'b1);
		endcase
		return r;
	endfunction

endpackage

### sv/lcd4_front.sv
module lcd4_front (
	input  logic            push,
	output logic            full,
	input  lcd4_pkg::req_t  req,
	input  logic            q_full,
	output logic            q_wr,
	output lcd4_pkg::cmd_t  q_cmd
);
	import lcd4_pkg::*;

	logic       keep;
	logic [7:0] addr;

	assign full = q_full;
	assign addr = req.column + ROW_OFFSET[req.row[1:0]];

	always_comb begin
		keep              = 1'b1;
		q_cmd.is_init     = 1'b0;
		q_cmd.rs          = 1'b0;
		q_cmd.data        = 8'h00;
		q_cmd.long_settle = 1'b0;
		unique case (req.req_type)
			REQ_INIT: begin
				q_cmd.is_init = 1'b1;
			end
			REQ_CLEAR: begin
				q_cmd.data        = CMD_CLEAR;
				q_cmd.long_settle = 1'b1;
			end
			REQ_HOME: begin
				q_cmd.data = CMD_SET_DDR;
			end
			REQ_CURSOR: begin
				// rows 4..7 are dropped
				keep       = ~req.row[2];
				q_cmd.data = CMD_SET_DDR | addr;
			end
			REQ_CHAR: begin
				q_cmd.rs   = 1'b1;
				q_cmd.data = req.char_code;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign q_wr = push & ~q_full & keep;

endmodule

### sv/lcd4_queue.sv
module lcd4_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  lcd4_pkg::cmd_t  wr_cmd,
	output logic            full,
	input  logic            rd,
	output lcd4_pkg::cmd_t  rd_cmd,
	output logic            empty
);
	import lcd4_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full   = count_q == CW'(QUEUE_DEPTH);
	assign empty  = count_q == '0;
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### sv/lcd4_back.sv
module lcd4_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  lcd4_pkg::cmd_t  q_cmd,
	output logic            q_rd,
	output logic            empty,
	input  logic            pop,
	output lcd4_pkg::res_t  res
);
	import lcd4_pkg::*;

	logic       busy_q;
	logic [3:0] step_q;
	cmd_t       cmd_q;
	logic       out_valid_q;
	res_t       out_q;
	res_t       cur;
	logic       adv;

	assign empty = ~out_valid_q;
	assign res   = out_q;
	assign q_rd  = ~busy_q & ~q_empty;
	assign adv   = busy_q & (~out_valid_q | pop);

	always_comb begin
		if (cmd_q.is_init) begin
			cur = init_strobe(step_q);
		end else if (!step_q[0]) begin
			cur = mk_res(cmd_q.rs, cmd_q.data[7:4], 16'd0, SETTLE_US, 1'b0);
		end else begin
			cur = mk_res(cmd_q.rs, cmd_q.data[3:0], 16'd0,
				cmd_q.long_settle ? LONG_BYTE_US : BYTE_US, 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			cmd_q <= q_cmd;
		end
		if (adv) begin
			out_q <= cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_rd) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (adv) begin
				step_q <= step_q + 1'b1;
				if (cur.last_of_run) begin
					busy_q <= 1'b0;
				end
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### sv/char_lcd_4bit_command_sequencer.sv
// An accepted request goes through the queue and the back end's command register into
// the output register. The back end emits one strobe per cycle from its step counter
// while the output is empty or popped; it loads a command only after the last ends.
// A two-entry command queue lets the front take requests while the back works.
// Reset (arst_n low) empties the queue, stops the sequencer and marks the output empty.
module char_lcd_4bit_command_sequencer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  lcd4_pkg::req_t  req,
	output logic            empty,
	input  logic            pop,
	output lcd4_pkg::res_t  res
);
	import lcd4_pkg::*;

	logic q_wr;
	logic q_rd;
	logic q_full;
	logic q_empty;
	cmd_t wr_cmd;
	cmd_t rd_cmd;

	lcd4_front u_front (
		.push   (push),
		.full   (full),
		.req    (req),
		.q_full (q_full),
		.q_wr   (q_wr),
		.q_cmd  (wr_cmd)
	);

	lcd4_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wr_cmd (wr_cmd),
		.full   (q_full),
		.rd     (q_rd),
		.rd_cmd (rd_cmd),
		.empty  (q_empty)
	);

	lcd4_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_cmd   (rd_cmd),
		.q_rd    (q_rd),
		.empty   (empty),
		.pop     (pop),
		.res     (res)
	);

	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr |-> !q_full)
		else $error("command written into full queue");

	a_no_read_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |-> !q_empty)
		else $error("command read from empty queue");

	a_read_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |=> !q_rd)
		else $error("back end loaded two commands in a row");

endmodule

### tb/char_lcd_4bit_command_sequencer_checker.sv
module char_lcd_4bit_command_sequencer_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  logic           full,
	input  lcd4_pkg::req_t req,
	input  logic           empty,
	input  logic           pop,
	input  lcd4_pkg::res_t res,
	output int             fail_count,
	output int             outstanding
);
	import lcd4_pkg::*;

	localparam logic [15:0] POWER_ON_WAIT = 16'd50000;
	localparam logic [12:0] STROBE_SETTLE = 13'd50;
	localparam logic [12:0] BYTE_GAP      = 13'd40;
	localparam logic [12:0] LONG_SETTLE   = 13'd2000;
	localparam logic [12:0] WAKE_FIRST    = 13'd5000;
	localparam logic [12:0] WAKE_SECOND   = 13'd2000;

	localparam logic [3:0] WAKE_NIBBLE  = 4'h3;
	localparam logic [3:0] MODE4_NIBBLE = 4'h2;
	localparam logic [7:0] FN_SET_4BIT  = 8'h28;
	localparam logic [7:0] DISPLAY_OFF  = 8'h08;
	localparam logic [7:0] ENTRY_MODE   = 8'h06;
	localparam logic [7:0] DISPLAY_ON   = 8'h0C;

	res_t strobe_q[$];
	res_t want;
	int   mismatches = 0;

	assign fail_count = mismatches;
	initial outstanding = 0;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic add_strobe(input logic rs, input logic [3:0] nib,
			input logic [15:0] pre_us, input logic [12:0] after, input logic last);
		res_t s;
		s.reg_select     = rs;
		s.nibble         = nib;
		s.wait_before_us = pre_us;
		s.wait_after_us  = after;
		s.last_of_run    = last;
		strobe_q.push_back(s);
	endtask

	// high nibble first; the low nibble carries the byte settle
	task automatic add_byte(input logic rs, input logic [7:0] value,
			input logic [12:0] extra, input logic last);
		add_strobe(rs, value[7:4], 16'd0, STROBE_SETTLE, 1'b0);
		add_strobe(rs, value[3:0], 16'd0, STROBE_SETTLE + BYTE_GAP + extra, last);
	endtask

	function automatic logic [7:0] row_base(input logic [1:0] row);
		case (row)
			2'd0:    return 8'h00;
			2'd1:    return 8'h40;
			2'd2:    return 8'h14;
			default: return 8'h54;
		endcase
	endfunction

	task automatic predict_request(input req_t r);
		logic [7:0] addr;
		case (r.req_type)
			REQ_INIT: begin
				add_strobe(1'b0, WAKE_NIBBLE, POWER_ON_WAIT, STROBE_SETTLE + WAKE_FIRST, 1'b0);
				add_strobe(1'b0, WAKE_NIBBLE, 16'd0, STROBE_SETTLE + WAKE_SECOND, 1'b0);
				add_strobe(1'b0, WAKE_NIBBLE, 16'd0, STROBE_SETTLE, 1'b0);
				add_strobe(1'b0, MODE4_NIBBLE, 16'd0, STROBE_SETTLE, 1'b0);
				add_byte(1'b0, FN_SET_4BIT, 13'd0, 1'b0);
				add_byte(1'b0, DISPLAY_OFF, 13'd0, 1'b0);
				add_byte(1'b0, CMD_CLEAR, 13'd0, 1'b0);
				add_byte(1'b0, ENTRY_MODE, LONG_SETTLE, 1'b0);
				add_byte(1'b0, DISPLAY_ON, 13'd0, 1'b1);
			end
			REQ_CLEAR:  add_byte(1'b0, CMD_CLEAR, LONG_SETTLE, 1'b1);
			REQ_HOME:   add_byte(1'b0, CMD_SET_DDR, 13'd0, 1'b1);
			REQ_CURSOR: begin
				// rows above three produce nothing; address wraps at 8 bits
				if (r.row <= 3'd3) begin
					addr = r.column + row_base(r.row[1:0]);
					add_byte(1'b0, CMD_SET_DDR | addr, 13'd0, 1'b1);
				end
			end
			REQ_CHAR:   add_byte(1'b1, r.char_code, 13'd0, 1'b1);
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (strobe_q.size() == 0) begin
					report_mismatch($sformatf("unexpected strobe rs=%0d nibble=%h last=%0d",
						res.reg_select, res.nibble, res.last_of_run));
				end else begin
					want = strobe_q.pop_front();
					if (res.reg_select !== want.reg_select)
						report_mismatch($sformatf("reg_select got %0d want %0d",
							res.reg_select, want.reg_select));
					if (res.nibble !== want.nibble)
						report_mismatch($sformatf("nibble got %h want %h",
							res.nibble, want.nibble));
					if (res.wait_before_us !== want.wait_before_us)
						report_mismatch($sformatf("wait_before_us got %0d want %0d",
							res.wait_before_us, want.wait_before_us));
					if (res.wait_after_us !== want.wait_after_us)
						report_mismatch($sformatf("wait_after_us got %0d want %0d",
							res.wait_after_us, want.wait_after_us));
					if (res.last_of_run !== want.last_of_run)
						report_mismatch($sformatf("last_of_run got %0d want %0d",
							res.last_of_run, want.last_of_run));
				end
			end
			if (push && !full)
				predict_request(req);
			outstanding <= strobe_q.size();
		end
	end

endmodule

### tb/char_lcd_4bit_command_sequencer_tb.sv
module char_lcd_4bit_command_sequencer_tb;
	import lcd4_pkg::*;

	localparam int STALL_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 40;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic push   = 1'b0;
	logic pop    = 1'b0;
	req_t req    = '0;
	logic full;
	logic empty;
	res_t res;

	int fail_count;
	int outstanding;
	int stall_cycles = 0;
	bit tx_steady    = 1'b0;
	bit rx_steady    = 1'b0;
	bit hold_off_req = 1'b0;

	char_lcd_4bit_command_sequencer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.req    (req),
		.empty  (empty),
		.pop    (pop),
		.res    (res)
	);

	char_lcd_4bit_command_sequencer_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.req         (req),
		.empty       (empty),
		.pop         (pop),
		.res         (res),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic req_t make_request(input logic [2:0] kind, input logic [7:0] column,
			input logic [2:0] row, input logic [7:0] char_code);
		req_t r;
		r.req_type  = kind;
		r.column    = column;
		r.row       = row;
		r.char_code = char_code;
		return r;
	endfunction

	// mostly well-formed requests, some rejected rows and unknown kinds
	function automatic req_t random_request();
		req_t r;
		int   pick;
		r.column    = 8'($urandom_range(0, 255));
		r.char_code = 8'($urandom_range(0, 255));
		r.row       = 3'($urandom_range(0, 7));
		pick = $urandom_range(0, 99);
		if (pick < 6)
			r.req_type = REQ_INIT;
		else if (pick < 20)
			r.req_type = REQ_CLEAR;
		else if (pick < 34)
			r.req_type = REQ_HOME;
		else if (pick < 60) begin
			r.req_type = REQ_CURSOR;
			r.row      = 3'($urandom_range(0, 3));
		end else if (pick < 88)
			r.req_type = REQ_CHAR;
		else if (pick < 94) begin
			r.req_type = REQ_CURSOR;
			r.row      = 3'($urandom_range(4, 7));
		end else
			r.req_type = 3'($urandom_range(REQ_CHAR + 1, 7));
		return r;
	endfunction

	task automatic send_request(input req_t r);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		req  <= r;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	// outstanding is registered in the checker, so advance the clock before looking at it
	task automatic wait_for_drain();
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	initial begin
		int i;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send_request(make_request(REQ_INIT,   8'h00, 3'd0, 8'h00));
		send_request(make_request(REQ_CLEAR,  8'hFF, 3'd7, 8'hFF));
		send_request(make_request(REQ_HOME,   8'h5A, 3'd5, 8'hA5));
		send_request(make_request(REQ_CURSOR, 8'h00, 3'd0, 8'h00));
		send_request(make_request(REQ_CURSOR, 8'hFF, 3'd0, 8'hFF));
		send_request(make_request(REQ_CURSOR, 8'h00, 3'd1, 8'h00));
		send_request(make_request(REQ_CURSOR, 8'hFF, 3'd1, 8'h00));
		send_request(make_request(REQ_CURSOR, 8'h00, 3'd2, 8'h00));
		send_request(make_request(REQ_CURSOR, 8'hFF, 3'd2, 8'h00));
		send_request(make_request(REQ_CURSOR, 8'h00, 3'd3, 8'h00));
		send_request(make_request(REQ_CURSOR, 8'hFF, 3'd3, 8'h00));
		send_request(make_request(REQ_CURSOR, 8'h12, 3'd4, 8'h00));
		send_request(make_request(REQ_CURSOR, 8'hFF, 3'd7, 8'hFF));
		send_request(make_request(REQ_CHAR,   8'h00, 3'd0, 8'h00));
		send_request(make_request(REQ_CHAR,   8'hFF, 3'd7, 8'hFF));
		send_request(make_request(REQ_CHAR,   8'h33, 3'd2, 8'h5A));
		send_request(make_request(REQ_CHAR + 3'd1, 8'hFF, 3'd3, 8'hFF));
		send_request(make_request(REQ_CHAR + 3'd2, 8'h00, 3'd0, 8'h00));
		send_request(make_request(3'd7,       8'hFF, 3'd7, 8'hFF));
		send_request(make_request(REQ_INIT,   8'hFF, 3'd7, 8'hFF));
		wait_for_drain();

		for (i = 0; i < 60; i++) begin
			if ($urandom_range(0, 29) == 0)
				tx_steady = !tx_steady;
			send_request(random_request());
		end
		tx_steady = 1'b0;
		wait_for_drain();

		// back-to-back requests while the receiver holds off: fills the block
		tx_steady    = 1'b1;
		hold_off_req = 1'b1;
		for (i = 0; i < 40; i++)
			send_request(random_request());
		tx_steady = 1'b0;

		for (i = 0; i < 60; i++) begin
			if ($urandom_range(0, 29) == 0)
				tx_steady = !tx_steady;
			send_request(random_request());
		end

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		int gap;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rx_steady = !rx_steady;
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				gap = rx_steady ? 0 : $urandom_range(0, 14);
				if (gap > 0) begin
					pop <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			stall_cycles <= 0;
		else if (stall_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else
			stall_cycles <= stall_cycles + 1;
	end

endmodule
